@@ rtl/core/clock_page_replacement_top_assert.svh @@
// ----------------------------------------------------------------------------
// clock_page_replacement_top assertion macros
// Shared property wrappers for the port checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication
`define CPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg
// Types and fixed field layout for the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SWEEP,
		ST_EVICT,
		ST_DONE
	} state_t;

	localparam int CFG_W       = 5;
	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

	localparam int PAGE_IN_W   = 16;
	localparam int FRAME_OUT_W = 4;
	localparam int FAULT_W     = 32;
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	localparam int OUT_FRAME_LSB = 0;
	localparam int OUT_EVICT_LSB = OUT_FRAME_LSB + FRAME_OUT_W;
	localparam int OUT_FAULT_LSB = OUT_EVICT_LSB + PAGE_IN_W;
	localparam int OUT_USED_W    = OUT_FAULT_LSB + FAULT_W;
	localparam int M_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W     = M_TDATA_W - OUT_USED_W;

	localparam int M_TUSER_W  = 2;
	localparam int USER_HIT   = 0;
	localparam int USER_EVICT = 1;

endpackage

@@ rtl/core/cpr_ram.sv @@
// ----------------------------------------------------------------------------
// cpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/clock_page_replacement_top.sv @@
// One item is taken at a time. A hit ends the serial tag search at its frame; a fault
// searches all n frames in use, then sweeps the hand, clearing set reference bits, and
// then evicts. The time is set by the serial tag search through the single read port
// of the page RAM and by the hand sweep.
// Reset: all frames empty, reference bits clear, hand 0, fault count 0,
// frames_in_use 16. Page RAM is not cleared; no reset pass.
// ----------------------------------------------------------------------------
// clock_page_replacement_top
// Second-chance page replacement over a RAM of resident pages.
// ----------------------------------------------------------------------------
module clock_page_replacement_top import cpr_pkg::*; #(
	parameter int FRAME_COUNT = 16,
	parameter int PAGE_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [PAGE_IN_W-1:0] s_tdata,   // page_number
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // frame_index, evicted_page, fault_total, pad
	output logic [M_TUSER_W-1:0] m_tuser,   // hit, evicted_valid
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data   // frames_in_use
);

	localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int CNT_W = $clog2(FRAME_COUNT + 1);
	localparam logic [CNT_W-1:0] FRAMES_MAX = CNT_W'(FRAME_COUNT);

	state_t state_q, state_d;

	logic [CFG_W-1:0]       frames_q;
	logic [PAGE_BITS-1:0]   page_q;
	logic [CNT_W-1:0]       scan_q;
	logic                   chk_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [IDX_W-1:0]       pos_q;
	logic [IDX_W-1:0]       hand_q;
	logic [FAULT_W-1:0]     fault_q;
	logic [FRAME_COUNT-1:0] valid_q;
	logic [FRAME_COUNT-1:0] ref_q;

	logic                   res_hit_q;
	logic [IDX_W-1:0]       res_frame_q;
	logic                   res_ev_valid_q;
	logic [PAGE_BITS-1:0]   res_ev_page_q;

	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;
	logic [M_TUSER_W-1:0]   m_tuser_q;

	logic [CNT_W-1:0]       n_act;
	logic [31:0]            page_ext;
	logic [PAGE_BITS-1:0]   page_in;
	logic [PAGE_BITS-1:0]   rd_page;
	logic [IDX_W-1:0]       rd_addr;
	logic                   issue;
	logic                   match;
	logic                   search_miss;
	logic [CNT_W-1:0]       pos_plus;
	logic [IDX_W-1:0]       pos_wrap;
	logic [IDX_W-1:0]       sweep_start;
	logic                   in_xfer;
	logic                   out_free;
	logic                   load_out;
	logic                   ram_we;
	logic [31:0]            frame_ext;
	logic [31:0]            ev_ext;

	// active frame count, clamped to 1..FRAME_COUNT
	always_comb begin
		if (frames_q == '0) begin
			n_act = CNT_W'(1);
		end else if (32'(frames_q) > 32'(FRAME_COUNT)) begin
			n_act = FRAMES_MAX;
		end else begin
			n_act = CNT_W'(frames_q);
		end
	end

	assign page_ext    = 32'(s_tdata);
	assign page_in     = page_ext[PAGE_BITS-1:0];

	assign issue       = (scan_q < n_act);
	assign match       = chk_s1 && valid_q[idx_s1] && (rd_page == page_q);
	assign search_miss = !issue && !chk_s1;

	assign pos_plus    = CNT_W'(pos_q) + CNT_W'(1);
	assign pos_wrap    = (pos_plus == n_act) ? '0 : pos_plus[IDX_W-1:0];
	assign sweep_start = (CNT_W'(hand_q) < n_act) ? hand_q : '0;

	assign out_free    = !m_tvalid_q || m_tready;

	cpr_ram #(
		.WIDTH(PAGE_BITS),
		.DEPTH(FRAME_COUNT)
	) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (page_q),
		.raddr (rd_addr),
		.rdata (rd_page)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (match) begin
					state_d = ST_DONE;
				end else if (search_miss) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (!ref_q[pos_q]) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		ram_we   = 1'b0;
		load_out = 1'b0;
		rd_addr  = scan_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SWEEP: begin
				rd_addr = pos_q;
			end
			ST_EVICT: begin
				ram_we = 1'b1;
			end
			ST_DONE: begin
				load_out = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign in_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			frames_q   <= FRAMES_RESET;
			scan_q     <= '0;
			chk_s1     <= 1'b0;
			pos_q      <= '0;
			hand_q     <= '0;
			fault_q    <= '0;
			valid_q    <= '0;
			ref_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				frames_q <= cfg_data;
			end
			if (in_xfer) begin
				scan_q <= '0;
				chk_s1 <= 1'b0;
			end else if (state_q == ST_SEARCH) begin
				if (issue) begin
					scan_q <= scan_q + CNT_W'(1);
				end
				chk_s1 <= issue;
				if (match) begin
					ref_q[idx_s1] <= 1'b1;
				end else if (search_miss) begin
					pos_q <= sweep_start;
				end
			end else if (state_q == ST_SWEEP) begin
				if (ref_q[pos_q]) begin
					ref_q[pos_q] <= 1'b0;
					pos_q        <= pos_wrap;
				end
			end else if (state_q == ST_EVICT) begin
				valid_q[pos_q] <= 1'b1;
				hand_q         <= pos_wrap;
				if (fault_q != FAULT_MAX) begin
					fault_q <= fault_q + FAULT_W'(1);
				end
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign frame_ext = 32'(res_frame_q);
	assign ev_ext    = 32'(res_ev_page_q);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			page_q <= page_in;
		end
		if (state_q == ST_SEARCH) begin
			idx_s1 <= scan_q[IDX_W-1:0];
			if (match) begin
				res_hit_q      <= 1'b1;
				res_frame_q    <= idx_s1;
				res_ev_valid_q <= 1'b0;
				res_ev_page_q  <= '0;
			end
		end
		if (state_q == ST_EVICT) begin
			res_hit_q      <= 1'b0;
			res_frame_q    <= pos_q;
			res_ev_valid_q <= valid_q[pos_q];
			res_ev_page_q  <= valid_q[pos_q] ? rd_page : '0;
		end
		if (load_out) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, fault_q, ev_ext[PAGE_IN_W-1:0],
				frame_ext[FRAME_OUT_W-1:0]};
			m_tuser_q <= {res_ev_valid_q, res_hit_q};
		end
	end

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign cfg_ready = 1'b1;

endmodule

@@ rtl/core/cpr_checker.sv @@
// ----------------------------------------------------------------------------
// cpr_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "clock_page_replacement_top_assert.svh"

module cpr_checker import cpr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	logic                 r_hit;
	logic                 r_evict;
	logic [PAGE_IN_W-1:0] r_ev_page;
	logic [FAULT_W-1:0]   r_fault;

	assign r_hit     = m_tuser[USER_HIT];
	assign r_evict   = m_tuser[USER_EVICT];
	assign r_ev_page = m_tdata[OUT_EVICT_LSB +: PAGE_IN_W];
	assign r_fault   = m_tdata[OUT_FAULT_LSB +: FAULT_W];

	`CPR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`CPR_ASSERT_NOW(a_hit_no_evict, m_tvalid && r_hit, !r_evict, "hit reports an eviction")
	`CPR_ASSERT_NOW(a_ev_page_zero, m_tvalid && !r_evict, r_ev_page == '0, "evicted page not zero")
	`CPR_ASSERT_NOW(a_fault_counted, m_tvalid && !r_hit, r_fault != '0, "fault without fault count")

endmodule

bind clock_page_replacement_top cpr_checker u_cpr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
